>>> hdl/sbct_pkg.sv
// sbct_pkg: shared types and widths for the sphere/box contact test pipeline
// no dependencies
`default_nettype none

package sbct_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAG_WIDTH   = COORD_WIDTH - 1;
    // difference of two coords needs one more bit
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 2;
    localparam int ROOT_WIDTH  = SUM_WIDTH / 2;
    localparam int PROD_WIDTH  = MAG_WIDTH + COORD_WIDTH;
    localparam int QUO_WIDTH   = PROD_WIDTH;
    // remainder width: divisor is at most ROOT_WIDTH bits
    localparam int REM_WIDTH   = ROOT_WIDTH + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] sphere_x;
        logic signed [COORD_WIDTH-1:0] sphere_y;
        logic signed [COORD_WIDTH-1:0] sphere_z;
        logic        [MAG_WIDTH-1:0]   sphere_radius;
        logic signed [COORD_WIDTH-1:0] box_x;
        logic signed [COORD_WIDTH-1:0] box_y;
        logic signed [COORD_WIDTH-1:0] box_z;
        logic        [MAG_WIDTH-1:0]   box_half_x;
        logic        [MAG_WIDTH-1:0]   box_half_y;
        logic        [MAG_WIDTH-1:0]   box_half_z;
    } item_t;

    typedef struct packed {
        logic hit;
        logic centers_coincide;
    } result_t;

    // per-axis context carried down the pipe
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] s;
        logic signed [COORD_WIDTH:0]   lo_bound;
        logic signed [COORD_WIDTH:0]   hi_bound;
        logic                          neg;
    } axis_t;

    typedef struct packed {
        axis_t [2:0]           ax;
        logic [2:0][MAG_WIDTH-1:0] mag;
        logic [MAG_WIDTH-1:0]  radius;
    } ctx_t;

endpackage

`default_nettype wire

>>> hdl/sbct_sqrt.sv
// sbct_sqrt: pipelined restoring square root, one result bit per stage
// depends on sbct_pkg
`default_nettype none

module sbct_sqrt (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic [sbct_pkg::SUM_WIDTH-1:0]     radicand,
    input  wire sbct_pkg::ctx_t                     in_ctx,
    output logic                                    out_valid,
    output logic [sbct_pkg::ROOT_WIDTH-1:0]         root,
    output sbct_pkg::ctx_t                          out_ctx
);
    localparam int N  = sbct_pkg::ROOT_WIDTH;
    localparam int RW = sbct_pkg::ROOT_WIDTH + 2;

    logic [N:0]                           v_reg;
    logic [N:0][sbct_pkg::SUM_WIDTH-1:0]  num_reg;
    logic [N:0][RW-1:0]                   rem_reg;
    logic [N:0][N-1:0]                    q_reg;
    sbct_pkg::ctx_t [N:0]                 ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= radicand;
        rem_reg[0] <= '0;
        q_reg[0]   <= '0;
        ctx_reg[0] <= in_ctx;
    end

    // stage k handles root bit N-1-k
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        logic [RW-1:0] diff;
        always_comb
        begin
            rem_next = {rem_reg[k][RW-3:0], num_reg[k][sbct_pkg::SUM_WIDTH-1 -: 2]};
            trial    = {q_reg[k], 2'b01};
            diff     = rem_next - trial;
        end
        always_ff @(posedge clk)
        begin
            num_reg[k+1] <= {num_reg[k][sbct_pkg::SUM_WIDTH-3:0], 2'b00};
            ctx_reg[k+1] <= ctx_reg[k];
            if (rem_next >= trial)
            begin
                rem_reg[k+1] <= diff;
                q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root      = q_reg[N];
    assign out_ctx   = ctx_reg[N];

endmodule

`default_nettype wire

>>> hdl/sbct_div.sv
// sbct_div: pipelined restoring divider, one quotient bit per stage, three lanes
// depends on sbct_pkg
`default_nettype none

module sbct_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic [2:0][sbct_pkg::PROD_WIDTH-1:0]  dividend,
    input  wire logic [sbct_pkg::ROOT_WIDTH-1:0]       divisor,
    input  wire sbct_pkg::ctx_t                        in_ctx,
    input  wire logic                                  in_zero,
    output logic                                       out_valid,
    output logic [2:0][sbct_pkg::QUO_WIDTH-1:0]        quotient,
    output sbct_pkg::ctx_t                             out_ctx,
    output logic                                       out_zero
);
    localparam int N  = sbct_pkg::PROD_WIDTH;
    localparam int RW = sbct_pkg::REM_WIDTH;

    logic [N:0]                          v_reg;
    logic [N:0][sbct_pkg::ROOT_WIDTH-1:0] dvs_reg;
    sbct_pkg::ctx_t [N:0]                ctx_reg;
    logic [N:0]                          z_reg;
    logic [N:0][2:0][N-1:0]              num_reg;
    logic [N:0][2:0][RW-1:0]             rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg[0] <= divisor;
        ctx_reg[0] <= in_ctx;
        z_reg[0]   <= in_zero;
        num_reg[0] <= dividend;
        rem_reg[0] <= '0;
    end

    // numerator shifts out msb first; quotient bits shift into its low end
    for (genvar k = 0; k < N; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            dvs_reg[k+1] <= dvs_reg[k];
            ctx_reg[k+1] <= ctx_reg[k];
            z_reg[k+1]   <= z_reg[k];
        end
        for (genvar a = 0; a < 3; a++)
        begin : g_lane
            logic [RW:0] rem_next;
            always_comb
            begin
                rem_next = {rem_reg[k][a], num_reg[k][a][N-1]};
            end
            always_ff @(posedge clk)
            begin
                if (rem_next >= {2'b00, dvs_reg[k]})
                begin
                    rem_reg[k+1][a] <= RW'(rem_next - {2'b00, dvs_reg[k]});
                    num_reg[k+1][a] <= {num_reg[k][a][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1][a] <= rem_next[RW-1:0];
                    num_reg[k+1][a] <= {num_reg[k][a][N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quotient  = num_reg[N];
    assign out_ctx   = ctx_reg[N];
    assign out_zero  = z_reg[N];

endmodule

`default_nettype wire

>>> hdl/sphere_box_contact_test_core.sv
// sphere_box_contact_test_core: top level of the sphere/box contact test
// depends on sbct_pkg, sbct_sqrt, sbct_div
// pipe: the start edge takes the word into 4 front stages, then root, product,
//   divide, probe and compare stages lead to the result word
// throughput: one test per cycle, busy is tied low; the pipe depth is set by the
//   bit-per-stage square root and the bit-per-stage divider
// reset: rst_n clears every valid bit, so no word is in flight after reset
// the receiver cannot stall; done pulses for one cycle with the result word
`default_nettype none

module sphere_box_contact_test_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sbct_pkg::item_t   item,
    output logic                   done,
    output sbct_pkg::result_t      result
);
    localparam int CW = sbct_pkg::COORD_WIDTH;
    localparam int MW = sbct_pkg::MAG_WIDTH;
    localparam int DW = sbct_pkg::DIFF_WIDTH;

    // every stage moves each cycle, so the core never refuses a word
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // stage 1: register the input word
    logic            s1_v_reg;
    sbct_pkg::item_t s1_item_reg;

    // stage 2: differences, magnitudes and box bounds
    logic                        s2_v_reg;
    sbct_pkg::ctx_t              s2_ctx_reg;

    // stage 3: squares of the magnitudes
    logic                               s3_v_reg;
    logic [2:0][sbct_pkg::SQ_WIDTH-1:0] s3_sq_reg;
    sbct_pkg::ctx_t                     s3_ctx_reg;

    // stage 4: sum of squares
    logic                              s4_v_reg;
    logic [sbct_pkg::SUM_WIDTH-1:0]    s4_sum_reg;
    sbct_pkg::ctx_t                    s4_ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // per-axis views of the registered word
    logic signed [2:0][CW-1:0] s_ax;
    logic signed [2:0][CW-1:0] b_ax;
    logic        [2:0][MW-1:0] h_ax;
    assign s_ax = {s1_item_reg.sphere_z, s1_item_reg.sphere_y, s1_item_reg.sphere_x};
    assign b_ax = {s1_item_reg.box_z, s1_item_reg.box_y, s1_item_reg.box_x};
    assign h_ax = {s1_item_reg.box_half_z, s1_item_reg.box_half_y, s1_item_reg.box_half_x};

    sbct_pkg::ctx_t s2_ctx_next;
    always_comb
    begin
        s2_ctx_next.radius = s1_item_reg.sphere_radius;
        for (int a = 0; a < 3; a++)
        begin
            logic signed [DW-1:0] d;
            logic        [DW-1:0] m;
            d = DW'(signed'(b_ax[a])) - DW'(signed'(s_ax[a]));
            m = d[DW-1] ? DW'(-d) : DW'(d);
            s2_ctx_next.mag[a]         = m[MW-1:0] | {MW{1'b0}};
            s2_ctx_next.ax[a].s        = s_ax[a];
            s2_ctx_next.ax[a].neg      = d[DW-1];
            s2_ctx_next.ax[a].lo_bound = (CW+1)'(signed'(b_ax[a])) - (CW+1)'({1'b0, h_ax[a]});
            s2_ctx_next.ax[a].hi_bound = (CW+1)'(signed'(b_ax[a])) + (CW+1)'({1'b0, h_ax[a]});
        end
    end

    // the magnitude can reach 2^32 - 1, one bit past the mag field; keep it aside
    logic [2:0][DW-1:0] s2_magw_reg;
    logic [2:0][DW-1:0] magw_next;
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [DW-1:0] d;
            d = DW'(signed'(b_ax[a])) - DW'(signed'(s_ax[a]));
            magw_next[a] = d[DW-1] ? DW'(-d) : DW'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        s2_ctx_reg  <= s2_ctx_next;
        s2_magw_reg <= magw_next;
        for (int a = 0; a < 3; a++)
        begin
            s3_sq_reg[a] <= sbct_pkg::SQ_WIDTH'(s2_magw_reg[a] * s2_magw_reg[a]);
        end
        s3_ctx_reg <= s2_ctx_reg;
        s4_sum_reg <= sbct_pkg::SUM_WIDTH'(s3_sq_reg[0]) + sbct_pkg::SUM_WIDTH'(s3_sq_reg[1])
                    + sbct_pkg::SUM_WIDTH'(s3_sq_reg[2]);
        s4_ctx_reg <= s3_ctx_reg;
    end

    // wide magnitudes ride alongside the ctx through the root
    logic [2:0][DW-1:0] s3_magw_reg;
    logic [2:0][DW-1:0] s4_magw_reg;
    always_ff @(posedge clk)
    begin
        s3_magw_reg <= s2_magw_reg;
        s4_magw_reg <= s3_magw_reg;
    end

    // square root
    logic                             sq_v;
    logic [sbct_pkg::ROOT_WIDTH-1:0]  sq_root;
    sbct_pkg::ctx_t                   sq_ctx;

    sbct_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .radicand  (s4_sum_reg),
        .in_ctx    (s4_ctx_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_ctx   (sq_ctx)
    );

    // delay line keeps the wide magnitudes aligned with the root
    localparam int SQD = sbct_pkg::ROOT_WIDTH + 1;
    logic [SQD-1:0][2:0][DW-1:0] magd_reg;
    always_ff @(posedge clk)
    begin
        magd_reg[0] <= s4_magw_reg;
        for (int k = 1; k < SQD; k++)
        begin
            magd_reg[k] <= magd_reg[k-1];
        end
    end

    // stage 5: radius times magnitude per axis
    logic                                    s5_v_reg;
    logic [2:0][sbct_pkg::PROD_WIDTH-1:0]    s5_prod_reg;
    logic [sbct_pkg::ROOT_WIDTH-1:0]         s5_root_reg;
    sbct_pkg::ctx_t                          s5_ctx_reg;
    logic                                    s5_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else
        begin
            s5_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            s5_prod_reg[a] <= sbct_pkg::PROD_WIDTH'(sq_ctx.radius * magd_reg[SQD-1][a]);
        end
        // root of a nonzero sum is nonzero; a zero root marks coincident centers
        s5_root_reg <= (sq_root == '0) ? sbct_pkg::ROOT_WIDTH'(1) : sq_root;
        s5_zero_reg <= (sq_root == '0);
        s5_ctx_reg  <= sq_ctx;
    end

    // divider
    logic                                   dv_v;
    logic [2:0][sbct_pkg::QUO_WIDTH-1:0]    dv_q;
    sbct_pkg::ctx_t                         dv_ctx;
    logic                                   dv_zero;

    sbct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_v_reg),
        .dividend  (s5_prod_reg),
        .divisor   (s5_root_reg),
        .in_ctx    (s5_ctx_reg),
        .in_zero   (s5_zero_reg),
        .out_valid (dv_v),
        .quotient  (dv_q),
        .out_ctx   (dv_ctx),
        .out_zero  (dv_zero)
    );

    // stage 6: probe point per axis, kept signed per element for the compares
    localparam int PW = sbct_pkg::QUO_WIDTH + 2;
    logic                          s6_v_reg;
    logic signed [PW-1:0]          s6_p_reg [3];
    sbct_pkg::ctx_t                s6_ctx_reg;
    logic                          s6_zero_reg;

    // stage 7: bound compares
    logic                   done_reg;
    sbct_pkg::result_t      result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s6_v_reg <= dv_v;
            done_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [PW-1:0] sw;
            logic signed [PW-1:0] qw;
            sw = PW'(signed'(dv_ctx.ax[a].s));
            qw = dv_zero ? '0 : signed'(PW'({2'b00, dv_q[a]}));
            s6_p_reg[a] <= dv_ctx.ax[a].neg ? sw - qw : sw + qw;
        end
        s6_ctx_reg  <= dv_ctx;
        s6_zero_reg <= dv_zero;
    end

    always_comb
    begin
        result_next.centers_coincide = s6_zero_reg;
        result_next.hit = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (!(s6_p_reg[a] > PW'(s6_ctx_reg.ax[a].lo_bound)
                  && s6_p_reg[a] < PW'(s6_ctx_reg.ax[a].hi_bound)))
            begin
                result_next.hit = 1'b0;
            end
        end
    end

    sbct_pkg::result_t out_reg;
    always_ff @(posedge clk)
    begin
        out_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

>>> hdl/sbct_checker.sv
// sbct_checker: port-level assertions for sphere_box_contact_test_core
// depends on sbct_pkg; bound to the top level below
`default_nettype none

module sbct_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire sbct_pkg::result_t result,
    input  wire logic              done
);
    // edges from taking a word to taking its result
    localparam int LAT = sbct_pkg::ROOT_WIDTH + sbct_pkg::PROD_WIDTH + 9;

    // core never refuses a word
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // no word comes out of an idle pipe right after reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("done right after reset");

    // a result word is always fully known
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("result unknown on done");

    // every accepted word comes back after the fixed pipe depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted word");

endmodule

bind sphere_box_contact_test_core sbct_checker u_sbct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .result (result),
    .done   (done)
);

`default_nettype wire

>>> bench/sphere_box_contact_test_core_test.sv
// sphere_box_contact_test_core_test: self-checking bench for the sphere/box contact test
// depends on sbct_pkg and sphere_box_contact_test_core
`default_nettype none

module sphere_box_contact_test_core_test;
    import sbct_pkg::*;

    localparam int LATENCY    = 107;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 1600;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;

    sphere_box_contact_test_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // words waiting to be sent, and contact results predicted for sent words
    item_t   pending_words[$];
    result_t expected_contacts[$];

    int  send_idle_pct = 24;    // chance in 100 that the driver holds off a cycle
    bit  hold_send = 1'b0;      // driver pauses entirely while set
    bit  stim_done = 1'b0;
    int  fail_count = 0;
    longint unsigned cycle_count = 0;

    // floor square root of a 66-bit sum of squares
    function automatic logic [65:0] floor_root(logic [65:0] n);
        logic [65:0] r;
        logic [65:0] t;
        logic [131:0] sq;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            t = r | (66'd1 << b);
            sq = t * t;
            if (sq <= {66'd0, n})
                r = t;
        end
        return r;
    endfunction

    // contact test: probe point = sphere center + radius * d / |d|, per axis truncated
    function automatic result_t predict_contact(item_t w);
        logic signed [33:0] s[3];
        logic signed [33:0] bc[3];
        logic signed [33:0] hf[3];
        logic signed [33:0] d[3];
        logic [32:0] mag[3];
        logic [65:0] sum;
        logic [65:0] len;
        logic [95:0] q;
        logic signed [99:0] p;
        result_t r;
        s[0] = w.sphere_x;  s[1] = w.sphere_y;  s[2] = w.sphere_z;
        bc[0] = w.box_x;    bc[1] = w.box_y;    bc[2] = w.box_z;
        hf[0] = {3'b0, w.box_half_x};
        hf[1] = {3'b0, w.box_half_y};
        hf[2] = {3'b0, w.box_half_z};
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = bc[i] - s[i];
            mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            sum = sum + 66'(mag[i]) * 66'(mag[i]);
        end
        r.centers_coincide = (sum == 0);
        len = r.centers_coincide ? '0 : floor_root(sum);
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p = 100'(s[i]);
            if (len != 0) begin
                q = (96'(w.sphere_radius) * 96'(mag[i])) / 96'(len);
                p = d[i] < 0 ? p - $signed({4'b0, q}) : p + $signed({4'b0, q});
            end
            if (!(p > 100'(bc[i] - hf[i]) && p < 100'(bc[i] + hf[i])))
                r.hit = 1'b0;
        end
        return r;
    endfunction

    // driver: one word per accepted start, start held high across back-to-back words
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                expected_contacts.push_back(predict_contact(item));
            if ((!start || !busy) && pending_words.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct) begin
                start <= 1'b1;
                item  <= pending_words.pop_front();
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // monitor: done marks a result word for this cycle only
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_contacts.size() == 0) begin
                $display("%0t: unexpected result hit=%b coincide=%b", $time,
                         result.hit, result.centers_coincide);
                fail_count++;
            end else begin
                result_t e;
                e = expected_contacts.pop_front();
                if (e.hit !== result.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, result.hit);
                    fail_count++;
                end
                if (e.centers_coincide !== result.centers_coincide) begin
                    $display("%0t: centers_coincide expected %b actual %b", $time,
                             e.centers_coincide, result.centers_coincide);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_mag();
        case ($urandom_range(4))
            0: return '0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(3000));
            default: return 31'($urandom);
        endcase
    endfunction

    // mostly near-miss geometry so hits and misses both occur
    function automatic item_t random_word();
        item_t w;
        w.sphere_x = rand_coord();
        w.sphere_y = rand_coord();
        w.sphere_z = rand_coord();
        w.sphere_radius = rand_mag();
        w.box_half_x = rand_mag();
        w.box_half_y = rand_mag();
        w.box_half_z = rand_mag();
        if ($urandom_range(99) < 60) begin
            int sc;
            sc = $urandom_range(24);
            w.box_x = w.sphere_x + ($signed($urandom) >>> sc);
            w.box_y = w.sphere_y + ($signed($urandom) >>> sc);
            w.box_z = w.sphere_z + ($signed($urandom) >>> sc);
            w.sphere_radius = 31'($urandom) >> sc;
            w.box_half_x = 31'($urandom) >> sc;
            w.box_half_y = 31'($urandom) >> sc;
            w.box_half_z = 31'($urandom) >> sc;
            if ($urandom_range(9) == 0)
                {w.box_x, w.box_y, w.box_z} = {w.sphere_x, w.sphere_y, w.sphere_z};
        end else begin
            w.box_x = rand_coord();
            w.box_y = rand_coord();
            w.box_z = rand_coord();
        end
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_contacts.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        item_t w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: coincident centers, zero half extents, extreme corners
        w = '0;
        w.box_half_x = 31'd10; w.box_half_y = 31'd10; w.box_half_z = 31'd10;
        pending_words.push_back(w);                       // coincide, hit
        w.box_half_y = '0;
        pending_words.push_back(w);                       // coincide, empty box
        w = '0;
        w.sphere_x = 32'h8000_0000; w.sphere_y = 32'h8000_0000; w.sphere_z = 32'h8000_0000;
        w.box_x = 32'h7fff_ffff; w.box_y = 32'h7fff_ffff; w.box_z = 32'h7fff_ffff;
        w.sphere_radius = '1;
        w.box_half_x = '1; w.box_half_y = '1; w.box_half_z = '1;
        pending_words.push_back(w);                       // longest direction
        {w.sphere_x, w.box_x} = {w.box_x, w.sphere_x};
        pending_words.push_back(w);                       // mixed signs
        w = '0;
        w.box_x = 32'sd100; w.sphere_radius = 31'd50;
        w.box_half_x = 31'd60; w.box_half_y = 31'd1; w.box_half_z = 31'd1;
        pending_words.push_back(w);                       // probe inside
        w.sphere_radius = 31'd40;
        pending_words.push_back(w);                       // probe on the lower face
        w.box_x = -32'sd100;
        pending_words.push_back(w);                       // negative direction
        w = '0;
        w.box_x = 32'sd1; w.box_y = 32'sd1; w.box_z = 32'sd1;
        w.sphere_radius = '1;
        w.box_half_x = '1; w.box_half_y = '1; w.box_half_z = '1;
        pending_words.push_back(w);                       // huge radius, tiny direction
        for (int i = 0; i < 12; i++) begin
            w = '0;
            w.sphere_x = rand_coord(); w.box_x = rand_coord();
            w.sphere_radius = rand_mag(); w.box_half_x = rand_mag();
            w.box_half_y = '1; w.box_half_z = '1;
            w.box_y = 32'(i); w.sphere_y = 32'(i);
            pending_words.push_back(w);
        end
        wait_drained();

        // random phases; the middle one pauses until everything is back
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 79 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++)
                pending_words.push_back(random_word());
            if (ph == 1) begin
                while (pending_words.size() > 250) @(posedge clk);
                hold_send = 1'b1;
                while (start || expected_contacts.size() > 0) @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire
